FILE: src/ipcl_pkg.sv
`timescale 1ns / 1ps

package ipcl_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 64;
  localparam int CLASS_WIDTH_DEFAULT = 8;

  localparam int ADDR_W   = 32;
  localparam int LEN_W    = 6;
  localparam int CLS_W    = 8;
  localparam int STATUS_W = 2;
  localparam int MAX_LEN  = 32;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic REG_DEFAULT_CLASS = 1'b0;
  localparam logic REG_DENY_CLASS    = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BADNET = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
    logic [ADDR_W-1:0] m;
    if (len >= LEN_W'(MAX_LEN)) begin
      m = '1;
    end else begin
      m = ~({ADDR_W{1'b1}} >> len);
    end
    return m;
  endfunction

endpackage

FILE: src/ipcl_ram.sv
`timescale 1ns / 1ps

module ipcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/ip_prefix_class_lookup_top.sv
`timescale 1ns / 1ps
// IPv4 prefix classifier with a rule table of TABLE_DEPTH entries.
// Input channel (in_valid / in_stall): cmd selects insert (network, prefix_len,
// class_id) or lookup (address). Output channel (out_valid / out_stall): one
// word per input word with status, result_class, matched, matched_len, denied.
// Configuration: cfg_write with cfg_index 0 sets the default class, 1 the
// banned class; write only while the block is idle.
// Each word but a rejected insert scans the occupied rules (at most
// TABLE_DEPTH) one per cycle through the single read port of the rule RAM
// and one shared compare unit. The result then passes the resolve and done
// states to the output register; a rejected insert goes from acceptance
// straight to the done state. One word is worked on at a time: in_stall
// is high from acceptance until the result moves to the output register,
// so a new word is taken only once the last one has left.
// A finished result waits in a holding stage while out_stall is high; the
// output register holds its word until it is taken.
// Reset empties the table (the fill count goes to zero, no clearing pass)
// and sets the default class to 0 and the banned class to 1.
module ip_prefix_class_lookup_top
  import ipcl_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT,
  parameter int CLASS_WIDTH = CLASS_WIDTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [CLS_W-1:0]    cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                cmd,
  input  logic [ADDR_W-1:0]   address,
  input  logic [LEN_W-1:0]    prefix_len,
  input  logic [CLS_W-1:0]    class_id,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] status,
  output logic [CLS_W-1:0]    result_class,
  output logic                matched,
  output logic [LEN_W-1:0]    matched_len,
  output logic                denied
);

  localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNTW = $clog2(TABLE_DEPTH + 1);
  localparam int CXW  = (CLASS_WIDTH > CLS_W) ? CLASS_WIDTH : CLS_W;
  localparam int EW   = ADDR_W + LEN_W + CLASS_WIDTH;

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_SCAN    = 4'b0010,
    S_RESOLVE = 4'b0100,
    S_DONE    = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [CLS_W-1:0] default_class, deny_class;

  logic                   q_cmd;
  logic [ADDR_W-1:0]      q_addr;
  logic [LEN_W-1:0]       q_len;
  logic [CLASS_WIDTH-1:0] q_cls;

  logic [CNTW-1:0] cnt;
  logic [CNTW-1:0] ridx;
  logic            rv;
  logic [AW-1:0]   rslot;

  logic                   found;
  logic [AW-1:0]          slot;
  logic                   pfx_hit;
  logic [LEN_W-1:0]       best_len;
  logic [CLASS_WIDTH-1:0] best_cls;
  logic                   host_hit;
  logic [CLASS_WIDTH-1:0] host_cls;

  logic [STATUS_W-1:0]    res_status;
  logic [CLASS_WIDTH-1:0] res_cls;
  logic                   res_matched;
  logic [LEN_W-1:0]       res_len;
  logic                   res_denied;

  logic                   accept, issue, scan_end, out_load, room;
  logic                   in_net_ok;
  logic [CXW-1:0]         in_cls_ext, def_ext, ban_ext, res_cls_ext;
  logic [CLASS_WIDTH-1:0] def_m, ban_m;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [EW-1:0]          ram_wdata, ram_rdata;
  logic [ADDR_W-1:0]      e_net;
  logic [LEN_W-1:0]       e_len;
  logic [CLASS_WIDTH-1:0] e_cls;
  logic                   key_hit, host_match, pfx_match;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign issue    = (state == S_SCAN) && (ridx < cnt);
  assign scan_end = (state == S_SCAN) && !issue && !rv;
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);
  assign room     = (cnt < CNTW'(TABLE_DEPTH));

  assign in_net_ok = (prefix_len == '0) ||
                     ((prefix_len <= LEN_W'(MAX_LEN)) &&
                      ((address & ~prefix_mask(prefix_len)) == '0));

  assign in_cls_ext = CXW'(class_id);
  assign def_ext    = CXW'(default_class);
  assign ban_ext    = CXW'(deny_class);
  assign def_m      = def_ext[CLASS_WIDTH-1:0];
  assign ban_m      = ban_ext[CLASS_WIDTH-1:0];
  assign res_cls_ext = CXW'(res_cls);

  assign {e_net, e_len, e_cls} = ram_rdata;

  assign key_hit    = (e_net == q_addr) && (e_len == q_len);
  assign host_match = (e_len == '0) && (e_net == q_addr);
  assign pfx_match  = (e_len != '0) && (e_len <= LEN_W'(MAX_LEN)) &&
                      ((q_addr & prefix_mask(e_len)) == e_net);

  assign ram_we    = (state == S_RESOLVE) && (q_cmd == CMD_INSERT) && (found || room);
  assign ram_waddr = found ? slot : cnt[AW-1:0];
  assign ram_wdata = {q_addr, q_len, q_cls};

  ipcl_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (issue),
    .raddr (ridx[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (cmd == CMD_INSERT && !in_net_ok) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_next = S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cnt           <= '0;
      rv            <= 1'b0;
      out_valid     <= 1'b0;
      default_class <= '0;
      deny_class    <= CLS_W'(1);
    end else begin
      state <= state_next;
      rv    <= issue;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_DEFAULT_CLASS: default_class <= cfg_data;
          REG_DENY_CLASS:    deny_class    <= cfg_data;
          default: ;
        endcase
      end
      if (ram_we && !found) begin
        cnt <= cnt + CNTW'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rslot <= ridx[AW-1:0];
    if (accept) begin
      q_cmd      <= cmd;
      q_addr     <= address;
      q_len      <= prefix_len;
      q_cls      <= in_cls_ext[CLASS_WIDTH-1:0];
      ridx       <= '0;
      found      <= 1'b0;
      slot       <= '0;
      pfx_hit    <= 1'b0;
      best_len   <= '0;
      best_cls   <= '0;
      host_hit   <= 1'b0;
      host_cls   <= '0;
      res_status <= ST_BADNET;
      res_cls    <= '0;
      res_matched <= 1'b0;
      res_len    <= '0;
      res_denied <= 1'b0;
    end
    if (issue) begin
      ridx <= ridx + CNTW'(1);
    end
    if (rv) begin
      if (q_cmd == CMD_INSERT) begin
        if (!found && key_hit) begin
          found <= 1'b1;
          slot  <= rslot;
        end
      end else begin
        if (!host_hit && host_match) begin
          host_hit <= 1'b1;
          host_cls <= e_cls;
        end
        if (pfx_match && (!pfx_hit || e_len > best_len)) begin
          pfx_hit  <= 1'b1;
          best_len <= e_len;
          best_cls <= e_cls;
        end
      end
    end
    if (state == S_RESOLVE) begin
      if (q_cmd == CMD_INSERT) begin
        res_status  <= (found || room) ? ST_OK : ST_FULL;
        res_cls     <= '0;
        res_matched <= 1'b0;
        res_len     <= '0;
        res_denied  <= 1'b0;
      end else if (pfx_hit) begin
        res_status  <= ST_OK;
        res_cls     <= best_cls;
        res_matched <= 1'b1;
        res_len     <= best_len;
        res_denied  <= (best_cls == ban_m);
      end else if (host_hit) begin
        res_status  <= ST_OK;
        res_cls     <= host_cls;
        res_matched <= 1'b1;
        res_len     <= '0;
        res_denied  <= (host_cls == ban_m);
      end else begin
        res_status  <= ST_OK;
        res_cls     <= def_m;
        res_matched <= 1'b0;
        res_len     <= '0;
        res_denied  <= (def_m == ban_m);
      end
    end
    if (out_load) begin
      status       <= res_status;
      result_class <= res_cls_ext[CLS_W-1:0];
      matched      <= res_matched;
      matched_len  <= res_len;
      denied       <= res_denied;
    end
  end

endmodule

FILE: src/ipcl_checker.sv
`timescale 1ns / 1ps

module ipcl_checker
  import ipcl_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [STATUS_W-1:0] status,
  input logic [CLS_W-1:0]    result_class,
  input logic                matched,
  input logic [LEN_W-1:0]    matched_len,
  input logic                denied
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(result_class) &&
      $stable(matched) && $stable(matched_len) && $stable(denied))
    else $error("stalled output word changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a word is in progress");

  a_insert_fields_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> !matched && result_class == '0 &&
      matched_len == '0 && !denied)
    else $error("rejected insert carries lookup fields");

  a_len_needs_match: assert property (@(posedge clk) disable iff (rst)
    out_valid && matched_len != '0 |-> matched && status == ST_OK &&
      matched_len <= LEN_W'(MAX_LEN))
    else $error("prefix length reported without a match");

endmodule

bind ip_prefix_class_lookup_top ipcl_checker u_ipcl_checker (.*);
